[design/adsd_pkg.sv]
// ----------------------------------------------------------------------------
// adsd_pkg
// Shared types, operation codes and the 14-segment font for the
// alphanumeric display scan driver.
// ----------------------------------------------------------------------------
package adsd_pkg;

    localparam int SCAN_STEP_W = 4;
    localparam int CODE_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int HALF_W      = 7;
    localparam int FONT_DEPTH  = 96;
    localparam int FONT_IDX_W  = 7;

    localparam logic [CODE_W-1:0] BLANK_CODE = 8'h20;
    localparam logic [CODE_W-1:0] FIRST_CODE = 8'h20;

    typedef enum logic [1:0] {
        OP_WRITE_CHAR = 2'd0,
        OP_SET_FLAGS  = 2'd1,
        OP_SCAN_TICK  = 2'd2
    } op_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] digit_select;
        logic [BYTE_W-1:0] segment_byte;
    } scan_result_t;

    // per printable code 32..127: {half one mask, half two mask}, bit k lit
    localparam logic [15:0] FONT_TABLE [FONT_DEPTH] = '{
        16'h0000, 16'h7F7F, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0004,
        16'h0000, 16'h0000, 16'h0000, 16'h4025, 16'h0000, 16'h4001, 16'h0000, 16'h0048,
        16'h3F00, 16'h0024, 16'h5B01, 16'h0F01, 16'h6601, 16'h6D01, 16'h7D01, 16'h0128,
        16'h7F01, 16'h6F01, 16'h0000, 16'h0000, 16'h0018, 16'h0000, 16'h0042, 16'h0000,
        16'h0000, 16'h7701, 16'h7918, 16'h3900, 16'h3042, 16'h7901, 16'h7101, 16'h3D01,
        16'h7601, 16'h0924, 16'h1F00, 16'h7018, 16'h3800, 16'h360A, 16'h3612, 16'h3F00,
        16'h7301, 16'h3F10, 16'h7311, 16'h6D01, 16'h0124, 16'h3E00, 16'h0612, 16'h3650,
        16'h005A, 16'h002A, 16'h4949, 16'h0000, 16'h0012, 16'h0000, 16'h0000, 16'h0800,
        16'h0000, 16'h7701, 16'h7918, 16'h3900, 16'h3042, 16'h7901, 16'h7101, 16'h3D01,
        16'h7601, 16'h0924, 16'h1F00, 16'h7018, 16'h3800, 16'h360A, 16'h3612, 16'h3F00,
        16'h7301, 16'h3F10, 16'h7311, 16'h6D01, 16'h0124, 16'h3E00, 16'h0612, 16'h3650,
        16'h005A, 16'h002A, 16'h4949, 16'h0000, 16'h0024, 16'h0000, 16'h0000, 16'h0000
    };

    // active-low segment byte for one font half, bit 0 always high
    function automatic logic [BYTE_W-1:0] seg_lookup(input logic [CODE_W-1:0] code,
                                                     input logic half);
        logic [FONT_IDX_W-1:0] idx;
        logic [15:0]           entry;
        logic [HALF_W-1:0]     mask;
        idx   = FONT_IDX_W'(code[6:0] - FIRST_CODE[6:0]);
        entry = FONT_TABLE[idx];
        mask  = half ? entry[6:0] : entry[14:8];
        // codes outside the printable range show the blank entry
        if (code[7] || (code[6:5] == 2'b00)) begin
            mask = '0;
        end
        return {~mask, 1'b1};
    endfunction

endpackage

[design/adsd_scan_core.sv]
// ----------------------------------------------------------------------------
// adsd_scan_core
// Character store, colon/dot flags and scan sequencer; forms the select
// and segment bytes for each scan tick.
// ----------------------------------------------------------------------------
module adsd_scan_core #(
    parameter int NUM_CHARS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  adsd_pkg::op_t         operation,
    input  logic [1:0]            char_position,
    input  logic [7:0]            char_code,
    input  logic                  colon_on,
    input  logic                  dot_on,
    output adsd_pkg::scan_result_t result
);
    import adsd_pkg::*;

    localparam int POS_W = (NUM_CHARS > 1) ? $clog2(NUM_CHARS) : 1;
    localparam logic [SCAN_STEP_W-1:0] LAST_STEP = SCAN_STEP_W'(2 * NUM_CHARS);

    logic [CODE_W-1:0]      char_store_reg  [NUM_CHARS];
    logic [CODE_W-1:0]      char_store_next [NUM_CHARS];
    logic [SCAN_STEP_W-1:0] scan_step_reg, scan_step_next;
    logic [CODE_W-1:0]      latched_reg, latched_next;
    logic                   colon_reg, colon_next;
    logic                   dot_reg, dot_next;

    logic                   pos_hit;
    logic                   is_last;
    logic [POS_W-1:0]       char_idx;
    logic [CODE_W-1:0]      shown_char;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHARS; i++) begin
                char_store_reg[i] <= BLANK_CODE;
            end
            scan_step_reg <= '0;
            latched_reg   <= BLANK_CODE;
            colon_reg     <= 1'b0;
            dot_reg       <= 1'b0;
        end else begin
            char_store_reg <= char_store_next;
            scan_step_reg  <= scan_step_next;
            latched_reg    <= latched_next;
            colon_reg      <= colon_next;
            dot_reg        <= dot_next;
        end
    end

    always_comb begin
        char_store_next = char_store_reg;
        scan_step_next  = scan_step_reg;
        latched_next    = latched_reg;
        colon_next      = colon_reg;
        dot_next        = dot_reg;

        pos_hit    = ({1'b0, char_position} < 3'(NUM_CHARS));
        is_last    = (scan_step_reg >= LAST_STEP);
        char_idx   = scan_step_reg[POS_W:1];
        // even steps show the character being latched, odd steps the latched one
        shown_char = scan_step_reg[0] ? latched_reg : char_store_reg[char_idx];

        result.valid        = accept && (operation == OP_SCAN_TICK);
        result.digit_select = is_last ? 8'hFF : ~(8'd1 << scan_step_reg[2:0]);
        result.segment_byte = is_last ? {5'b11111, ~colon_reg, ~dot_reg, 1'b0}
                                      : seg_lookup(shown_char, scan_step_reg[0]);

        if (accept) begin
            unique case (operation)
                OP_WRITE_CHAR: begin
                    if (pos_hit) begin
                        char_store_next[char_position[POS_W-1:0]] = char_code;
                    end
                end
                OP_SET_FLAGS: begin
                    colon_next = colon_on;
                    dot_next   = dot_on;
                end
                OP_SCAN_TICK: begin
                    if (is_last) begin
                        scan_step_next = '0;
                    end else begin
                        if (!scan_step_reg[0]) begin
                            latched_next = char_store_reg[char_idx];
                        end
                        scan_step_next = scan_step_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_step_reg <= LAST_STEP)
        else $error("scan step beyond last step");

    a_wrap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && operation == OP_SCAN_TICK && is_last) |=> (scan_step_reg == '0))
        else $error("scan did not wrap after last step");

    a_latch_hold_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && operation == OP_SCAN_TICK && is_last) |=> $stable(latched_reg))
        else $error("latched character changed on last step");

    a_flags_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && operation == OP_SET_FLAGS) |=> ($stable(colon_reg) && $stable(dot_reg)))
        else $error("colon or dot flag changed without a set request");
`endif

endmodule

[design/adsd_out_stage.sv]
// ----------------------------------------------------------------------------
// adsd_out_stage
// Result register between the scan core and the master port; takes a new
// request whenever the held result is empty or being taken.
// ----------------------------------------------------------------------------
module adsd_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  adsd_pkg::scan_result_t result,
    output logic                   in_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata
);
    import adsd_pkg::*;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] select_reg;
    logic [BYTE_W-1:0] segment_reg;

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {segment_reg, select_reg};

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && result.valid) begin
            select_reg  <= result.digit_select;
            segment_reg <= result.segment_byte;
        end
    end

endmodule

[design/alnum_display_scan_driver.sv]
// ----------------------------------------------------------------------------
// alnum_display_scan_driver
// Scan driver for a multiplexed four-character 14-segment display.
// ----------------------------------------------------------------------------
// One request is taken per clock while s_tready is high. Character writes
// and colon/dot updates change state and give no result; each scan tick
// gives one result from the result register, selecting the next of
// 2*NUM_CHARS+1 scan steps. The font lookup and step counter sit between
// the stored state and that register, and s_tready follows m_tready
// whenever a result is held. No clearing pass follows reset.
module alnum_display_scan_driver #(
    parameter int NUM_CHARS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], char_position[3:2], char_code[11:4], colon_on[12], dot_on[13]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // digit_select[7:0], segment_byte[15:8]
    output logic [15:0] m_tdata
);
    import adsd_pkg::*;

    logic         accept;
    scan_result_t result;

    assign accept = s_tvalid && s_tready;

    adsd_scan_core #(
        .NUM_CHARS (NUM_CHARS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .operation     (op_t'(s_tdata[1:0])),
        .char_position (s_tdata[3:2]),
        .char_code     (s_tdata[11:4]),
        .colon_on      (s_tdata[12]),
        .dot_on        (s_tdata[13]),
        .result        (result)
    );

    adsd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[verif/tb_alnum_display_scan_driver.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alnum_display_scan_driver
// Streams character writes, colon/dot updates, unused operation codes and
// scan ticks into the display driver. A local model of the scan predicts
// every select/segment byte pair, and each result is checked in order.
// Sender bursts and receiver stalls vary throughout, with one long
// receiver hold that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_alnum_display_scan_driver;
    import adsd_pkg::*;

    localparam int          NUM_CHARS    = 4;
    localparam int          LAST_STEP    = 2 * NUM_CHARS;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int          LONG_HOLD    = 120;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          LIMIT_CYCLES = 400000;

    // lit-segment masks per printable code 32..127: {half one, half two}
    localparam logic [15:0] GLYPH_MASKS [96] = '{
        16'h0000, 16'h7F7F, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0004,
        16'h0000, 16'h0000, 16'h0000, 16'h4025, 16'h0000, 16'h4001, 16'h0000, 16'h0048,
        16'h3F00, 16'h0024, 16'h5B01, 16'h0F01, 16'h6601, 16'h6D01, 16'h7D01, 16'h0128,
        16'h7F01, 16'h6F01, 16'h0000, 16'h0000, 16'h0018, 16'h0000, 16'h0042, 16'h0000,
        16'h0000, 16'h7701, 16'h7918, 16'h3900, 16'h3042, 16'h7901, 16'h7101, 16'h3D01,
        16'h7601, 16'h0924, 16'h1F00, 16'h7018, 16'h3800, 16'h360A, 16'h3612, 16'h3F00,
        16'h7301, 16'h3F10, 16'h7311, 16'h6D01, 16'h0124, 16'h3E00, 16'h0612, 16'h3650,
        16'h005A, 16'h002A, 16'h4949, 16'h0000, 16'h0012, 16'h0000, 16'h0000, 16'h0800,
        16'h0000, 16'h7701, 16'h7918, 16'h3900, 16'h3042, 16'h7901, 16'h7101, 16'h3D01,
        16'h7601, 16'h0924, 16'h1F00, 16'h7018, 16'h3800, 16'h360A, 16'h3612, 16'h3F00,
        16'h7301, 16'h3F10, 16'h7311, 16'h6D01, 16'h0124, 16'h3E00, 16'h0612, 16'h3650,
        16'h005A, 16'h002A, 16'h4949, 16'h0000, 16'h0024, 16'h0000, 16'h0000, 16'h0000
    };

    typedef struct packed {
        logic [7:0] digit_select;
        logic [7:0] segment_byte;
    } scan_bytes_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // display model state
    logic [7:0]  char_slots [NUM_CHARS];
    logic [3:0]  scan_pos;
    logic [7:0]  held_char;
    logic        colon_lit;
    logic        dot_lit;

    scan_bytes_t expected_scan [$];
    int          errors      = 0;
    int          cycle_count = 0;

    // sender burst control
    int          burst_left   = 1;
    bit          gaps_enabled = 1'b1;

    // receiver stall control
    int          hold_tokens = 0;
    int          hold_served = 0;
    int          stall_left  = 0;
    int          ready_mode  = 0;
    int          mode_left   = 0;
    int          pattern_ctr = 0;

    alnum_display_scan_driver #(
        .NUM_CHARS (NUM_CHARS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic logic [15:0] pack_request(input logic [1:0] op, input logic [1:0] pos,
                                                 input logic [7:0] code, input logic colon,
                                                 input logic dot);
        return {2'b00, dot, colon, code, pos, op};
    endfunction

    function automatic logic [7:0] glyph_byte(input logic [7:0] code, input logic half);
        logic [15:0] entry;
        logic [6:0]  mask;
        mask = '0;
        if (code >= 8'd32 && code <= 8'd127) begin
            entry = GLYPH_MASKS[code - 8'd32];
            mask  = half ? entry[6:0] : entry[14:8];
        end
        return 8'hFF ^ {mask, 1'b0};
    endfunction

    task automatic reset_display_model();
        for (int i = 0; i < NUM_CHARS; i++) begin
            char_slots[i] = 8'h20;
        end
        scan_pos  = '0;
        held_char = 8'h20;
        colon_lit = 1'b0;
        dot_lit   = 1'b0;
    endtask

    task automatic predict_display(input logic [15:0] word);
        logic [1:0]  op;
        logic [1:0]  pos;
        logic [7:0]  code;
        scan_bytes_t res;
        op   = word[1:0];
        pos  = word[3:2];
        code = word[11:4];
        case (op)
            OP_WRITE_CHAR: begin
                if (pos < NUM_CHARS) begin
                    char_slots[pos] = code;
                end
            end
            OP_SET_FLAGS: begin
                colon_lit = word[12];
                dot_lit   = word[13];
            end
            OP_SCAN_TICK: begin
                if (scan_pos >= LAST_STEP) begin
                    // colon/dot step keeps the latched character
                    res.digit_select = 8'hFF;
                    res.segment_byte = {5'b11111, ~colon_lit, ~dot_lit, 1'b0};
                    scan_pos = '0;
                end else begin
                    if (!scan_pos[0]) begin
                        held_char = char_slots[scan_pos[3:1] % NUM_CHARS];
                    end
                    res.digit_select = ~(8'h01 << scan_pos);
                    res.segment_byte = glyph_byte(held_char, scan_pos[0]);
                    scan_pos = scan_pos + 4'd1;
                end
                expected_scan.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_request(input logic [15:0] word);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        predict_display(word);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if (gaps_enabled) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_request(pack_request(OP_SCAN_TICK, 2'd0, 8'h00, 1'b0, 1'b0));
    endtask

    function automatic logic [7:0] pick_code();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5) return 8'($urandom_range(32, 127));
        if (sel == 6) begin
            case ($urandom_range(0, 5))
                0: return 8'h00;
                1: return 8'h1F;
                2: return 8'h20;
                3: return 8'h7F;
                4: return 8'h80;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // full scan straight after reset: spaces and both flags dark
    task automatic test_reset_display();
        send_ticks(LAST_STEP + 1);
    endtask

    // all segments lit, codes beyond both ends of the printable range
    task automatic test_extreme_codes();
        send_request(pack_request(OP_WRITE_CHAR, 2'd0, 8'h21, 1'b0, 1'b0));
        send_request(pack_request(OP_WRITE_CHAR, 2'd1, 8'hFF, 1'b0, 1'b0));
        send_request(pack_request(OP_WRITE_CHAR, 2'd2, 8'h00, 1'b0, 1'b0));
        send_request(pack_request(OP_WRITE_CHAR, 2'd3, 8'h7F, 1'b0, 1'b0));
        send_request(pack_request(OP_SET_FLAGS, 2'd0, 8'h00, 1'b1, 1'b0));
        send_ticks(LAST_STEP + 1);
    endtask

    // unused operation code must leave slot 0 and the flags alone
    task automatic test_ignored_op();
        send_request(pack_request(OP_UNUSED, 2'd0, 8'h80, 1'b0, 1'b1));
        send_ticks(1);
    endtask

    task automatic test_random_traffic(input int count);
        int         done;
        int         sel;
        logic [1:0] op;
        done = 0;
        while (done < count) begin
            sel = $urandom_range(0, 19);
            if (sel <= 10)      op = OP_SCAN_TICK;
            else if (sel <= 16) op = OP_WRITE_CHAR;
            else if (sel <= 18) op = OP_SET_FLAGS;
            else                op = OP_UNUSED;
            send_request(pack_request(op, 2'($urandom_range(0, 3)), pick_code(),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            if (op != OP_UNUSED) done++;
        end
    endtask

    // receiver holds off while ticks keep coming, so the block stalls its input
    task automatic test_backpressure();
        gaps_enabled = 1'b0;
        hold_tokens++;
        send_ticks(40);
        gaps_enabled = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (hold_served != hold_tokens) begin
            hold_served = hold_tokens;
            stall_left  = LONG_HOLD;
            m_tready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            pattern_ctr++;
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (pattern_ctr % 3 != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        scan_bytes_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_scan.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = expected_scan.pop_front();
                if (m_tdata[7:0] !== want.digit_select) begin
                    $display("%0t: digit_select expected %h actual %h",
                             $time, want.digit_select, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[15:8] !== want.segment_byte) begin
                    $display("%0t: segment_byte expected %h actual %h",
                             $time, want.segment_byte, m_tdata[15:8]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_alnum_display_scan_driver: errors");
            $finish;
        end
    end

    initial begin
        reset_display_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_display();
        test_extreme_codes();
        test_ignored_op();
        test_random_traffic(800);
        test_backpressure();
        test_random_traffic(860);

        if (s_tvalid) s_tvalid <= 1'b0;
        while (expected_scan.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("tb_alnum_display_scan_driver: clean");
        end else begin
            $display("tb_alnum_display_scan_driver: errors");
        end
        $finish;
    end

endmodule
